[hw/rtl/hsv_pkg.sv]
// ----------------------------------------------------------------------------
// hsv_pkg
// Shared widths, reciprocal constants and sector codes for the HSV to RGB565
// converter.
// ----------------------------------------------------------------------------
package hsv_pkg;

  // fixed field widths
  localparam int HUE_W  = 15;
  localparam int BYTE_W = 8;
  localparam int PIX_W  = 16;

  // default hue fraction bits (1/64 degree)
  localparam int HUE_FRAC_BITS_DEF = 6;

  // degrees per sector
  localparam int DEG_PER_SECTOR = 60;

  // divide by 60: q ~ (n * RECIP_60) >> RECIP_SHIFT, low by at most one
  localparam int RECIP_60    = 1092;
  localparam int RECIP_W     = 11;
  localparam int RECIP_SHIFT = 16;

  // sector codes, anything above the last one places like magenta to red
  localparam int SECT_RED_YELLOW    = 0;
  localparam int SECT_YELLOW_GREEN  = 1;
  localparam int SECT_GREEN_CYAN    = 2;
  localparam int SECT_CYAN_BLUE     = 3;
  localparam int SECT_BLUE_MAGENTA  = 4;

  // rgb565 field masks
  localparam logic [BYTE_W-1:0] RED_MASK   = 8'hF8;
  localparam logic [BYTE_W-1:0] GREEN_MASK = 8'hFC;

endpackage

[hw/rtl/hsv_to_rgb565_converter.sv]
// ----------------------------------------------------------------------------
// hsv_to_rgb565_converter
// Five-stage pipelined HSV to RGB888 / RGB565 pixel converter.
// ----------------------------------------------------------------------------
// Converts one pixel per clock unless a result waits at the output: a beat
// accepted on in_* passes through five register stages to out_*, the first
// one loaded by the edge that takes it in. A new beat is taken in every cycle
// that the output side takes one (or the output register is empty). The
// pipeline stalls as a whole when out_ready is low and a result is waiting.
// Each stage holds about one multiplier or one add and compare: stage 1 forms
// v*s and a reciprocal estimate of the sector, stage 2 finishes c = v*s/255
// and corrects the sector and the in-sector offset f, stage 3 forms c*f (or
// c*(W-f)), stage 4 estimates its division by W through a reciprocal, stage 5
// corrects it, places c and x on the channels, adds m and packs RGB565. Hue is
// not wrapped: sectors past the sixth use the placement of the sixth.
module hsv_to_rgb565_converter #(
  parameter int HUE_FRACTION_BITS = hsv_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [hsv_pkg::HUE_W-1:0]  in_hue,
  input  logic [hsv_pkg::BYTE_W-1:0] in_saturation,
  input  logic [hsv_pkg::BYTE_W-1:0] in_brightness,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [hsv_pkg::BYTE_W-1:0] out_red,
  output logic [hsv_pkg::BYTE_W-1:0] out_green,
  output logic [hsv_pkg::BYTE_W-1:0] out_blue,
  output logic [hsv_pkg::PIX_W-1:0]  out_packed_565
);

  localparam int HW        = hsv_pkg::HUE_W;
  localparam int BW        = hsv_pkg::BYTE_W;
  localparam int SECTOR_W  = hsv_pkg::DEG_PER_SECTOR << HUE_FRACTION_BITS;
  localparam int HUE_MAX   = (1 << HW) - 1;
  localparam int SECT_MAX  = HUE_MAX / SECTOR_W;
  localparam int SW        = $clog2(SECT_MAX + 1);
  localparam int FW        = $clog2(SECTOR_W);
  localparam int HIW       = HW - HUE_FRACTION_BITS;
  localparam int PW        = BW + FW;
  localparam int NW        = PW - HUE_FRACTION_BITS;
  localparam int RW        = hsv_pkg::RECIP_W;
  localparam int RS        = hsv_pkg::RECIP_SHIFT;

  localparam logic [RW-1:0] RECIP    = RW'(hsv_pkg::RECIP_60);
  localparam logic [HW:0]   SECT_W_H = (HW + 1)'(SECTOR_W);
  localparam logic [FW:0]   SECT_W_F = (FW + 1)'(SECTOR_W);
  localparam logic [NW-1:0] DEG_N    = NW'(hsv_pkg::DEG_PER_SECTOR);

  // global advance: the whole pipe moves unless a result is held
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // --------------------------------------------------------------------------
  // stage 1: v*s and sector estimate
  // --------------------------------------------------------------------------
  logic              v1_r;
  logic [HW-1:0]     hue1_r;
  logic [BW-1:0]     val1_r;
  logic [2*BW-1:0]   vs1_r;
  logic [SW-1:0]     qh1_r;
  logic [HIW+RW-1:0] qh_prod;

  assign qh_prod = (HIW + RW)'(in_hue[HW-1:HUE_FRACTION_BITS]) * (HIW + RW)'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hue1_r <= in_hue;
      val1_r <= in_brightness;
      vs1_r  <= (2 * BW)'(in_brightness) * (2 * BW)'(in_saturation);
      qh1_r  <= SW'(qh_prod >> RS);
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: c = v*s/255, sector and offset correction
  // --------------------------------------------------------------------------
  logic            v2_r;
  logic [BW-1:0]   c2_r;
  logic [BW-1:0]   val2_r;
  logic [SW-1:0]   sect2_r;
  logic [FW-1:0]   f2_r;
  logic [2*BW:0]   div255_sum;
  logic [HW:0]     hue_base;
  logic [HW:0]     hue_rem;
  logic            sect_low;

  // exact x/255 for any 8x8 product
  assign div255_sum = (2 * BW + 1)'(vs1_r) + (2 * BW + 1)'(vs1_r >> BW) + (2 * BW + 1)'(1);
  assign hue_base   = (HW + 1)'(qh1_r) * SECT_W_H;
  assign hue_rem    = (HW + 1)'(hue1_r) - hue_base;
  assign sect_low   = hue_rem >= SECT_W_H;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c2_r    <= div255_sum[2*BW-1:BW];
      val2_r  <= val1_r;
      sect2_r <= sect_low ? qh1_r + SW'(1) : qh1_r;
      f2_r    <= sect_low ? FW'(hue_rem - SECT_W_H) : FW'(hue_rem);
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: c*f in even sectors, c*(W-f) in odd ones
  // --------------------------------------------------------------------------
  logic          v3_r;
  logic [PW-1:0] prod3_r;
  logic [BW-1:0] c3_r;
  logic [BW-1:0] val3_r;
  logic [SW-1:0] sect3_r;
  logic [FW-1:0] frac_sel;

  assign frac_sel = sect2_r[0] ? FW'(SECT_W_F - (FW + 1)'(f2_r)) : f2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod3_r <= PW'(c2_r) * PW'(frac_sel);
      c3_r    <= c2_r;
      val3_r  <= val2_r;
      sect3_r <= sect2_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: divide by W, shift then reciprocal estimate of /60
  // --------------------------------------------------------------------------
  logic             v4_r;
  logic [NW-1:0]    n4_r;
  logic [BW-1:0]    qx4_r;
  logic [BW-1:0]    c4_r;
  logic [BW-1:0]    val4_r;
  logic [SW-1:0]    sect4_r;
  logic [NW-1:0]    n_shr;
  logic [NW+RW-1:0] qx_prod;

  assign n_shr   = NW'(prod3_r >> HUE_FRACTION_BITS);
  assign qx_prod = (NW + RW)'(n_shr) * (NW + RW)'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n4_r    <= n_shr;
      qx4_r   <= BW'(qx_prod >> RS);
      c4_r    <= c3_r;
      val4_r  <= val3_r;
      sect4_r <= sect3_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: correct x, place channels, add m, pack
  // --------------------------------------------------------------------------
  logic          out_valid_r;
  logic [BW-1:0] red_r;
  logic [BW-1:0] green_r;
  logic [BW-1:0] blue_r;
  logic [BW-1:0] val5_r;
  logic [NW-1:0] x_rem;
  logic [BW-1:0] x_val;
  logic [BW-1:0] m_val;
  logic [BW-1:0] r_pl;
  logic [BW-1:0] g_pl;
  logic [BW-1:0] b_pl;
  logic [BW-1:0] red_nxt;
  logic [BW-1:0] green_nxt;
  logic [BW-1:0] blue_nxt;

  assign x_rem = n4_r - NW'(qx4_r) * DEG_N;
  assign x_val = (x_rem >= DEG_N) ? qx4_r + BW'(1) : qx4_r;
  assign m_val = val4_r - c4_r;

  // sector placement of c and x
  always_comb begin
    case (sect4_r)
      SW'(hsv_pkg::SECT_RED_YELLOW): begin
        r_pl = c4_r;  g_pl = x_val; b_pl = '0;
      end
      SW'(hsv_pkg::SECT_YELLOW_GREEN): begin
        r_pl = x_val; g_pl = c4_r;  b_pl = '0;
      end
      SW'(hsv_pkg::SECT_GREEN_CYAN): begin
        r_pl = '0;    g_pl = c4_r;  b_pl = x_val;
      end
      SW'(hsv_pkg::SECT_CYAN_BLUE): begin
        r_pl = '0;    g_pl = x_val; b_pl = c4_r;
      end
      SW'(hsv_pkg::SECT_BLUE_MAGENTA): begin
        r_pl = x_val; g_pl = '0;    b_pl = c4_r;
      end
      default: begin
        r_pl = c4_r;  g_pl = '0;    b_pl = x_val;
      end
    endcase
  end

  assign red_nxt   = r_pl + m_val;
  assign green_nxt = g_pl + m_val;
  assign blue_nxt  = b_pl + m_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      val5_r  <= val4_r;
    end
  end

  // output port drive
  assign out_valid      = out_valid_r;
  assign out_red        = red_r;
  assign out_green      = green_r;
  assign out_blue       = blue_r;
  assign out_packed_565 = {red_r[BW-1:3], green_r[BW-1:2], blue_r[BW-1:3]};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------

  // corrected offset stays inside its sector
  a_f_in_sector: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> ((FW + 1)'(f2_r) < SECT_W_F))
    else $error("hue offset outside sector");

  // secondary component never exceeds chroma
  a_x_le_c: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (x_val <= c4_r))
    else $error("secondary component above chroma");

  // the strongest channel equals the brightness
  a_max_is_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (red_r == val5_r || green_r == val5_r || blue_r == val5_r))
    else $error("no channel equals brightness");

  // no channel exceeds the brightness
  a_le_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (red_r <= val5_r && green_r <= val5_r && blue_r <= val5_r))
    else $error("channel above brightness");

  // a held result freezes the whole pipe
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable({v1_r, v2_r, v3_r, v4_r, out_valid_r}))
    else $error("pipeline moved during stall");

endmodule

[tb/hsv_to_rgb565_converter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb565_converter_tb
// Drives pixels through the HSV to RGB565 converter with bursty input and a
// stalling output side. Every accepted pixel is predicted in the bench and
// each output beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module hsv_to_rgb565_converter_tb;

  // hue units per 60 degree sector at the default hue fraction
  localparam int unsigned SECTOR_W = hsv_pkg::DEG_PER_SECTOR << hsv_pkg::HUE_FRAC_BITS_DEF;
  localparam int unsigned HUE_TOP  = 6 * SECTOR_W - 1;
  localparam int unsigned HUE_MAX  = (1 << hsv_pkg::HUE_W) - 1;

  localparam int RANDOM_PIXELS  = 1450;
  localparam int PAUSE_ROUNDS   = 5;
  localparam int PAUSE_BURST    = 50;
  localparam int DRAIN_TAIL     = 20;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS    = 40;

  typedef struct packed {
    logic [hsv_pkg::BYTE_W-1:0] red;
    logic [hsv_pkg::BYTE_W-1:0] green;
    logic [hsv_pkg::BYTE_W-1:0] blue;
    logic [hsv_pkg::PIX_W-1:0]  packed_565;
  } rgb_pixel_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [hsv_pkg::HUE_W-1:0]  in_hue;
  logic [hsv_pkg::BYTE_W-1:0] in_saturation;
  logic [hsv_pkg::BYTE_W-1:0] in_brightness;
  logic                       out_valid;
  logic                       out_ready;
  logic [hsv_pkg::BYTE_W-1:0] out_red;
  logic [hsv_pkg::BYTE_W-1:0] out_green;
  logic [hsv_pkg::BYTE_W-1:0] out_blue;
  logic [hsv_pkg::PIX_W-1:0]  out_packed_565;

  rgb_pixel_t pending_pixels[$];
  int         mismatch_count;
  int         out_beats;
  int         burst_left;
  int         stuck_cycles;
  int         ready_mode;
  int         ready_cycle;

  hsv_to_rgb565_converter u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_hue         (in_hue),
    .in_saturation  (in_saturation),
    .in_brightness  (in_brightness),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_packed_565 (out_packed_565)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // expected color for one pixel: chroma, offset, sector placement, 565 packing
  function automatic rgb_pixel_t predict_pixel(input logic [hsv_pkg::HUE_W-1:0] hue,
                                               input logic [hsv_pkg::BYTE_W-1:0] sat,
                                               input logic [hsv_pkg::BYTE_W-1:0] val);
    int unsigned chroma, offset, sector, frac, second, r, g, b;
    rgb_pixel_t px;
    chroma = (int'(val) * int'(sat)) / 255;
    offset = int'(val) - chroma;
    sector = int'(hue) / SECTOR_W;
    frac   = int'(hue) % SECTOR_W;
    if (sector[0] == 1'b0) begin
      second = (chroma * frac) / SECTOR_W;
    end else begin
      second = (chroma * (SECTOR_W - frac)) / SECTOR_W;
    end
    // hue is not wrapped, every sector past the last named one places like magenta to red
    case (sector)
      hsv_pkg::SECT_RED_YELLOW: begin
        r = chroma; g = second; b = 0;
      end
      hsv_pkg::SECT_YELLOW_GREEN: begin
        r = second; g = chroma; b = 0;
      end
      hsv_pkg::SECT_GREEN_CYAN: begin
        r = 0; g = chroma; b = second;
      end
      hsv_pkg::SECT_CYAN_BLUE: begin
        r = 0; g = second; b = chroma;
      end
      hsv_pkg::SECT_BLUE_MAGENTA: begin
        r = second; g = 0; b = chroma;
      end
      default: begin
        r = chroma; g = 0; b = second;
      end
    endcase
    px.red        = 8'(r + offset);
    px.green      = 8'(g + offset);
    px.blue       = 8'(b + offset);
    px.packed_565 = {px.red[7:3], px.green[7:2], px.blue[7:3]};
    return px;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MAX_REPORTS) begin
      $display("mismatch on out beat %0d: %s got %0d want %0d", out_beats, what, got, want);
    end
    mismatch_count++;
  endtask

  // drop valid between beats that are not back to back
  task automatic sender_idle();
    in_valid <= 1'b0;
  endtask

  // send one pixel beat, bursts of random length with random gaps between them
  task automatic send_pixel(input int unsigned hue, input int unsigned sat,
                            input int unsigned val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_hue        <= hsv_pkg::HUE_W'(hue);
    in_saturation <= hsv_pkg::BYTE_W'(sat);
    in_brightness <= hsv_pkg::BYTE_W'(val);
    // ready is stable between edges, so look at it mid-cycle
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    pending_pixels.push_back(predict_pixel(hsv_pkg::HUE_W'(hue), hsv_pkg::BYTE_W'(sat),
                                           hsv_pkg::BYTE_W'(val)));
  endtask

  // hold off input until every pending pixel has come out
  task automatic wait_for_drain();
    sender_idle();
    while (pending_pixels.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic int unsigned pick_byte();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 255;
      2:       return $urandom_range(0, 1) ? 1 : 254;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic int unsigned pick_hue();
    int sector;
    case ($urandom_range(0, 9))
      0: return $urandom_range(HUE_TOP + 1, HUE_MAX);
      1, 2: begin
        // just on either side of a sector boundary
        sector = $urandom_range(1, 8);
        if ($urandom_range(0, 1)) begin
          return sector * SECTOR_W + $urandom_range(0, 2);
        end else begin
          return sector * SECTOR_W - 1 - $urandom_range(0, 2);
        end
      end
      default: return $urandom_range(0, HUE_TOP);
    endcase
  endfunction

  // full and empty channels, black, white and grey
  task automatic test_channel_extremes();
    send_pixel(0, 0, 0);
    send_pixel(0, 255, 255);
    send_pixel(0, 0, 255);
    send_pixel(0, 255, 0);
    send_pixel(HUE_TOP, 255, 255);
    send_pixel(HUE_TOP / 2, 0, 128);
  endtask

  // first and last hue of every sector at full saturation and value
  task automatic test_sector_boundaries();
    for (int s = 0; s < 6; s++) begin
      send_pixel(s * SECTOR_W, 255, 255);
      send_pixel(s * SECTOR_W + SECTOR_W - 1, 255, 255);
    end
  endtask

  // hue at or past 360 degrees keeps sector parity but places like the last sector
  task automatic test_hue_past_range();
    send_pixel(6 * SECTOR_W, 200, 230);
    send_pixel(7 * SECTOR_W, 200, 230);
    send_pixel(8 * SECTOR_W, 200, 230);
    send_pixel(HUE_MAX, 255, 255);
  endtask

  task automatic test_random_stream();
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      send_pixel(pick_hue(), pick_byte(), pick_byte());
    end
  endtask

  // bursts that each end with the pipeline fully drained
  task automatic test_pause_until_drained();
    for (int r = 0; r < PAUSE_ROUNDS; r++) begin
      for (int i = 0; i < PAUSE_BURST; i++) begin
        send_pixel(pick_hue(), pick_byte(), pick_byte());
      end
      wait_for_drain();
    end
  endtask

  // output side stalls on a pattern that changes every so often
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready   <= 1'b0;
      ready_mode  <= 0;
      ready_cycle <= 0;
    end else begin
      ready_cycle <= ready_cycle + 1;
      if (ready_cycle % 80 == 79) begin
        ready_mode <= $urandom_range(0, 3);
      end
      case (ready_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ((ready_cycle % 7) < 4);
      endcase
    end
  end

  // check each out beat against the oldest prediction
  always @(negedge clk) begin : check_out_beat
    rgb_pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected beat, packed_565", out_packed_565, -1);
      end else begin
        want = pending_pixels.pop_front();
        if (out_red !== want.red) report_mismatch("red", out_red, want.red);
        if (out_green !== want.green) report_mismatch("green", out_green, want.green);
        if (out_blue !== want.blue) report_mismatch("blue", out_blue, want.blue);
        if (out_packed_565 !== want.packed_565) begin
          report_mismatch("packed_565", out_packed_565, want.packed_565);
        end
      end
      out_beats++;
    end
  end

  // watchdog on cycles with no beat on either side
  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("hsv_to_rgb565_converter_tb failed");
        $finish;
      end
    end
  end

  initial begin
    mismatch_count = 0;
    out_beats      = 0;
    burst_left     = 0;
    stuck_cycles   = 0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_hue        <= '0;
    in_saturation <= '0;
    in_brightness <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_channel_extremes();
    test_sector_boundaries();
    test_hue_past_range();
    test_random_stream();
    test_pause_until_drained();

    sender_idle();
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("hsv_to_rgb565_converter_tb passed");
    end else begin
      $display("hsv_to_rgb565_converter_tb failed");
    end
    $finish;
  end

endmodule
